>>> rtl/core/line_follow_pid_drive_assert.svh
// Assertion macros for the line follower PID drive; clock and reset are clk and rst_n.
`ifndef LINE_FOLLOW_PID_DRIVE_ASSERT_SVH
`define LINE_FOLLOW_PID_DRIVE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check cons in the same cycle whenever ante holds.
`define LFPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LFPD_ASSERT_NOW(lbl, ante, cons, msg)
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/lfpd_pkg.sv
// Shared types, constants and the sensor error table for the line follower PID drive.
`default_nettype none

package lfpd_pkg;

    localparam int BASE_W     = 12;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int ERR_W      = 6;
    localparam int SUM_W      = 16;
    localparam int DERIV_W    = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_BITS  = 10;

    localparam logic [BASE_W-1:0]  BASE_SPEED_RST = 12'd300;
    localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 16'd3072;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST     = 16'd10;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST     = 16'd2560;
    localparam logic [LIMIT_W-1:0] INT_LIMIT_RST  = 15'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_SPEED = 3'd0,
        CFG_GAIN_P     = 3'd1,
        CFG_GAIN_I     = 3'd2,
        CFG_GAIN_D     = 3'd3,
        CFG_INT_LIMIT  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [BASE_W-1:0]  base_speed;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] integral_limit;
    } cfg_t;

    // Position error for a sensor pattern; the all-off pattern is handled by the caller.
    function automatic logic signed [ERR_W-1:0] err_lookup(input logic [3:0] pattern);
        logic signed [ERR_W-1:0] err;
        case (pattern)
            4'd1:    err = 6'sd30;
            4'd2:    err = 6'sd10;
            4'd3:    err = 6'sd20;
            4'd4:    err = -6'sd10;
            4'd7:    err = 6'sd10;
            4'd8:    err = -6'sd30;
            4'd10:   err = -6'sd20;
            4'd12:   err = -6'sd20;
            default: err = 6'sd0;
        endcase
        return err;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/line_follow_pid_drive.sv
// Line follower PID drive: top level with error state, PID pipeline and output register.
`default_nettype none

`include "line_follow_pid_drive_assert.svh"

// Takes one 4-bit sensor sample per transaction and returns one wheel command
// transaction per sample. A new sample is accepted every clock while in_stall
// is low. The error and integral update is registered at the accepting edge,
// and the multiply stage, the product sum and the clamp into the output
// register follow it in that order. The PID state is updated in the acceptance
// cycle, so back-to-back samples see each other's error and integral. When the
// output is stalled the stages fill up and in_stall rises only once every stage
// holds a transaction. Configuration writes take effect at once and belong
// between transactions.
module line_follow_pid_drive
    import lfpd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [3:0]               sensor_bits,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [BASE_W-1:0]             left_drive,
    output logic [BASE_W-1:0]             right_drive,
    output logic                          line_lost,
    output logic signed [ERR_W-1:0]       position_error
);

    localparam int PP_W  = GAIN_W + 1 + ERR_W;    // gain_p * error
    localparam int PI_W  = GAIN_W + 1 + SUM_W;    // gain_i * integral
    localparam int PD_W  = GAIN_W + 1 + DERIV_W;  // gain_d * derivative
    localparam int ACC_W = PI_W + 1;
    localparam int ADJ_W = ACC_W - FRAC_BITS;
    localparam int DRV_W = ADJ_W + 2;

    cfg_t cfg;

    lfpd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ---------------- handshake chain ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic out_free, s3_ready, s2_ready, s1_ready, in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_free;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_free)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- stage 1: error lookup and PID state ----------------
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [SUM_W-1:0]   error_sum_reg;
    logic                      lost_a;
    logic signed [ERR_W-1:0]   err_a;
    logic signed [SUM_W:0]     sum_raw;
    logic signed [SUM_W:0]     lim_pos;
    logic signed [SUM_W:0]     lim_neg;
    logic signed [SUM_W:0]     sum_clamped;
    logic signed [SUM_W-1:0]   sum_a;
    logic signed [DERIV_W-1:0] deriv_a;

    assign lost_a  = (sensor_bits == 4'd0);
    assign err_a   = lost_a ? prev_err_reg : err_lookup(sensor_bits);
    assign sum_raw = {error_sum_reg[SUM_W-1], error_sum_reg}
                   + {{(SUM_W+1-ERR_W){err_a[ERR_W-1]}}, err_a};
    assign lim_pos = {2'b00, cfg.integral_limit};
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (sum_raw > lim_pos)
            sum_clamped = lim_pos;
        else if (sum_raw < lim_neg)
            sum_clamped = lim_neg;
        else
            sum_clamped = sum_raw;
    end

    assign sum_a   = sum_clamped[SUM_W-1:0];
    assign deriv_a = {err_a[ERR_W-1], err_a} - {prev_err_reg[ERR_W-1], prev_err_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            error_sum_reg <= '0;
        end
        else if (in_accept)
        begin
            prev_err_reg  <= err_a;
            error_sum_reg <= sum_a;
        end
    end

    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [SUM_W-1:0]   s1_sum_reg;
    logic signed [DERIV_W-1:0] s1_deriv_reg;
    logic                      s1_lost_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_err_reg   <= err_a;
            s1_sum_reg   <= sum_a;
            s1_deriv_reg <= deriv_a;
            s1_lost_reg  <= lost_a;
        end
    end

    // ---------------- stage 2: gain products ----------------
    logic signed [PP_W-1:0] prod_p_next;
    logic signed [PI_W-1:0] prod_i_next;
    logic signed [PD_W-1:0] prod_d_next;

    assign prod_p_next = $signed({1'b0, cfg.gain_p}) * s1_err_reg;
    assign prod_i_next = $signed({1'b0, cfg.gain_i}) * s1_sum_reg;
    assign prod_d_next = $signed({1'b0, cfg.gain_d}) * s1_deriv_reg;

    logic signed [PP_W-1:0]  s2_prod_p_reg;
    logic signed [PI_W-1:0]  s2_prod_i_reg;
    logic signed [PD_W-1:0]  s2_prod_d_reg;
    logic signed [ERR_W-1:0] s2_err_reg;
    logic                    s2_lost_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_p_reg <= prod_p_next;
            s2_prod_i_reg <= prod_i_next;
            s2_prod_d_reg <= prod_d_next;
            s2_err_reg    <= s1_err_reg;
            s2_lost_reg   <= s1_lost_reg;
        end
    end

    // ---------------- stage 3: product sum ----------------
    logic signed [ACC_W-1:0] acc_next;

    assign acc_next = {{(ACC_W-PP_W){s2_prod_p_reg[PP_W-1]}}, s2_prod_p_reg}
                    + {{(ACC_W-PI_W){s2_prod_i_reg[PI_W-1]}}, s2_prod_i_reg}
                    + {{(ACC_W-PD_W){s2_prod_d_reg[PD_W-1]}}, s2_prod_d_reg};

    logic signed [ACC_W-1:0] s3_acc_reg;
    logic signed [ERR_W-1:0] s3_err_reg;
    logic                    s3_lost_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_acc_reg  <= acc_next;
            s3_err_reg  <= s2_err_reg;
            s3_lost_reg <= s2_lost_reg;
        end
    end

    // ---------------- output stage: scale and clamp ----------------
    // Floor shift plus one on a negative value with dropped bits = truncate toward zero.
    logic signed [ADJ_W-1:0] adj_floor;
    logic                    adj_round;
    logic signed [DRV_W-1:0] adj_wide;
    logic signed [DRV_W-1:0] rnd_wide;
    logic signed [DRV_W-1:0] base_wide;
    logic signed [DRV_W-1:0] left_raw;
    logic signed [DRV_W-1:0] right_raw;
    logic [BASE_W-1:0]       left_next;
    logic [BASE_W-1:0]       right_next;

    assign adj_floor = s3_acc_reg[ACC_W-1:FRAC_BITS];
    assign adj_round = s3_acc_reg[ACC_W-1] && (s3_acc_reg[FRAC_BITS-1:0] != '0);
    assign adj_wide  = {{(DRV_W-ADJ_W){adj_floor[ADJ_W-1]}}, adj_floor};
    assign rnd_wide  = {{(DRV_W-1){1'b0}}, adj_round};
    assign base_wide = {{(DRV_W-BASE_W){1'b0}}, cfg.base_speed};
    assign left_raw  = base_wide - adj_wide - rnd_wide;
    assign right_raw = base_wide + adj_wide + rnd_wide;

    always_comb
    begin
        if (s3_lost_reg || left_raw < 0)
            left_next = '0;
        else if (left_raw > base_wide)
            left_next = cfg.base_speed;
        else
            left_next = left_raw[BASE_W-1:0];

        if (s3_lost_reg || right_raw < 0)
            right_next = '0;
        else if (right_raw > base_wide)
            right_next = cfg.base_speed;
        else
            right_next = right_raw[BASE_W-1:0];
    end

    logic [BASE_W-1:0]       left_reg;
    logic [BASE_W-1:0]       right_reg;
    logic                    lost_reg;
    logic signed [ERR_W-1:0] err_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_free && s3_valid_reg)
        begin
            left_reg    <= left_next;
            right_reg   <= right_next;
            lost_reg    <= s3_lost_reg;
            err_out_reg <= s3_err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_drive     = left_reg;
    assign right_drive    = right_reg;
    assign line_lost      = lost_reg;
    assign position_error = err_out_reg;

    // ---------------- assertions ----------------
    logic signed [SUM_W:0] sum_chk;

    assign sum_chk = {error_sum_reg[SUM_W-1], error_sum_reg};

    `LFPD_ASSERT_NEXT(a_state_tracks_stage1, in_accept, s1_valid_reg && (prev_err_reg == s1_err_reg) && (error_sum_reg == s1_sum_reg), "PID state and stage 1 disagree")
    `LFPD_ASSERT_NEXT(a_lost_holds_error, in_accept && (sensor_bits == 4'd0), $stable(prev_err_reg), "previous error changed on a lost line")
    `LFPD_ASSERT_NEXT(a_integral_clamped, in_accept, (sum_chk <= $past(lim_pos)) && (sum_chk >= $past(lim_neg)), "integral outside its limit")
    `LFPD_ASSERT_NOW(a_lost_stops_wheels, out_valid_reg && lost_reg, (left_reg == '0) && (right_reg == '0), "drive nonzero with line lost")

endmodule

`default_nettype wire

>>> rtl/core/lfpd_cfg_regs.sv
// Configuration register file: base speed, PID gains and integral limit.
`default_nettype none

module lfpd_cfg_regs
    import lfpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASE_SPEED: cfg_next.base_speed     = cfg_data[BASE_W-1:0];
                CFG_GAIN_P:     cfg_next.gain_p         = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:     cfg_next.gain_i         = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:     cfg_next.gain_d         = cfg_data[GAIN_W-1:0];
                CFG_INT_LIMIT:  cfg_next.integral_limit = cfg_data[LIMIT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed     <= BASE_SPEED_RST;
            cfg_reg.gain_p         <= GAIN_P_RST;
            cfg_reg.gain_i         <= GAIN_I_RST;
            cfg_reg.gain_d         <= GAIN_D_RST;
            cfg_reg.integral_limit <= INT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire
